### rtl/core/mwr_pkg.sv
// shared types, widths and helpers for the windowed rms block
package mwr_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int CHAN_W     = 3;
  localparam int WLEN_W     = 8;
  localparam int RMS_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int SQ_W       = 15;
  localparam int QUO_W      = 31;
  localparam int ROOT_STEPS = 16;
  localparam int ROOT_CNT_W = 4;
  localparam int SREM_W     = 20;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 8'd100;

  typedef struct packed {
    logic accept;
    logic load_sq;
    logic update;
    logic clr_step;
    logic div_start;
    logic div_sel_total;
    logic div_step;
    logic sq_start;
    logic sq_step;
    logic save_chan;
    logic push;
  } mwr_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic clr_last;
    logic div_last;
    logic sq_last;
    logic out_free;
  } mwr_status_t;

  function automatic logic [SQ_W-1:0] square8(logic [SAMPLE_W-1:0] b);
    logic signed [2*SAMPLE_W-1:0] p;
    p = $signed(b) * $signed(b);
    return p[SQ_W-1:0];
  endfunction

endpackage

### rtl/core/mwr_ram.sv
// generic single write, single read ram with registered read
module mwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/mwr_ctrl.sv
// sequencer for the clearing pass and the update, divide, square root and output steps
module mwr_ctrl import mwr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        cfg_we,
  input  mwr_status_t status,
  output mwr_cmd_t    cmd,
  output logic        in_stall
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD, S_DIV_LD, S_DIV, S_SQ_LD, S_SQ, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   total_r, total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      total_r <= 1'b0;
    end else if (cfg_we) begin
      state_r <= S_CLEAR;
      total_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    total_nxt = total_r;
    cmd.div_sel_total = total_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !cfg_we) begin
          cmd.accept = 1'b1;
          total_nxt  = 1'b0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.load_sq = 1'b1;
        if (status.ch_ok) begin
          state_nxt = S_UPD;
        end else begin
          total_nxt = 1'b1;
          state_nxt = S_DIV_LD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        cmd.save_chan = total_r && status.ch_ok;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_SQ_LD;
        end
      end
      S_SQ_LD: begin
        cmd.sq_start = 1'b1;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (status.sq_last) begin
          if (total_r) begin
            state_nxt = S_OUT;
          end else begin
            total_nxt = 1'b1;
            state_nxt = S_DIV_LD;
          end
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || cfg_we;

endmodule

### rtl/core/mwr_dp.sv
// window store, square sums, serial divider and serial square root
module mwr_dp import mwr_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int MAX_WINDOW = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mwr_cmd_t            cmd,
  output mwr_status_t         status,
  input  logic                cfg_we,
  input  logic [WLEN_W-1:0]   cfg_wdata,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [RMS_W-1:0]    out_channel_rms,
  output logic [RMS_W-1:0]    out_overall_rms
);

  localparam int DEPTH = CHANNELS * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = $clog2((1 << (SQ_W - 1)) * MAX_WINDOW + 1);
  localparam int TW    = $clog2((1 << (SQ_W - 1)) * MAX_WINDOW * CHANNELS + 1);
  localparam int DW    = $clog2(MAX_WINDOW * CHANNELS + 1);
  localparam int NW    = TW + FRAC_W;
  localparam int DCW   = $clog2(NW);

  logic [WLEN_W-1:0]   wlen_r;
  logic [LW-1:0]       eff;
  logic [SW-1:0]       sum_r [CHANNELS];
  logic [PW-1:0]       pos_r [CHANNELS];
  logic [TW-1:0]       total_r;
  logic [CHAN_W-1:0]   ch_r;
  logic                ch_ok_r;
  logic [CW-1:0]       idx_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [PW-1:0]       pos_cur_r;
  logic [AW-1:0]       addr_r;
  logic [SQ_W-1:0]     old_sq_r, new_sq_r;
  logic [AW-1:0]       clr_cnt_r;

  logic                in_ok;
  logic [CW-1:0]       in_idx;
  logic [PW-1:0]       rd_pos_raw, rd_pos;
  logic [AW-1:0]       raddr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic [LW:0]         pos_inc;
  logic [PW-1:0]       pos_nxt;

  logic [NW-1:0]       num_r;
  logic [DW-1:0]       dsr_r;
  logic [DW-1:0]       rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [DCW-1:0]      div_cnt_r;
  logic [DW:0]         rem_sh;
  logic                q_bit;

  logic [2*ROOT_STEPS-1:0] x_r;
  logic [RMS_W-1:0]        root_r;
  logic [SREM_W-1:0]       srem_r;
  logic [ROOT_CNT_W-1:0]   sq_cnt_r;
  logic [SREM_W-1:0]       r4, trial;

  logic [RMS_W-1:0]    chan_rms_r;
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_channel_r;
  logic [RMS_W-1:0]    out_chan_rms_r, out_overall_r;

  always_comb begin
    if (wlen_r == '0) begin
      eff = LW'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      eff = LW'(MAX_WINDOW);
    end else begin
      eff = LW'(wlen_r);
    end
  end

  assign in_ok      = 32'(in_channel) < CHANNELS;
  assign in_idx     = CW'(in_channel);
  assign rd_pos_raw = in_ok ? pos_r[in_idx] : '0;
  assign rd_pos     = (LW'(rd_pos_raw) >= eff) ? '0 : rd_pos_raw;
  assign raddr      = AW'(32'(in_idx) * MAX_WINDOW + 32'(rd_pos));

  assign pos_inc = {1'b0, LW'(pos_cur_r)} + (LW + 1)'(1);
  assign pos_nxt = (pos_inc >= {1'b0, eff}) ? '0 : PW'(pos_inc);

  assign ram_we    = cmd.clr_step || cmd.update;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clr_step ? '0 : smp_r;

  mwr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // window state, cleared by reset and by a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_RESET;
      total_r   <= '0;
      clr_cnt_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (cfg_we) begin
      wlen_r    <= cfg_wdata;
      total_r   <= '0;
      clr_cnt_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.update) begin
        sum_r[idx_r] <= sum_r[idx_r] - SW'(old_sq_r) + SW'(new_sq_r);
        pos_r[idx_r] <= pos_nxt;
        total_r      <= total_r - TW'(old_sq_r) + TW'(new_sq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r       <= in_channel;
      ch_ok_r    <= in_ok;
      idx_r      <= in_idx;
      smp_r      <= in_sample;
      pos_cur_r  <= rd_pos;
      addr_r     <= raddr;
      chan_rms_r <= '0;
    end
    if (cmd.load_sq) begin
      old_sq_r <= square8(ram_rdata);
      new_sq_r <= square8(smp_r);
    end
    if (cmd.save_chan) begin
      chan_rms_r <= root_r;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign q_bit  = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      if (cmd.div_sel_total) begin
        num_r <= {total_r, FRAC_W'(0)};
        dsr_r <= DW'(32'(eff) * CHANNELS);
      end else begin
        num_r <= {TW'(sum_r[idx_r]), FRAC_W'(0)};
        dsr_r <= DW'(eff);
      end
      rem_r     <= '0;
      quo_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r     <= {num_r[NW-2:0], 1'b0};
      rem_r     <= q_bit ? DW'(rem_sh - {1'b0, dsr_r}) : DW'(rem_sh);
      quo_r     <= {quo_r[QUO_W-2:0], q_bit};
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
  end

  // digit by digit square root, one result bit a cycle
  assign r4    = {srem_r[SREM_W-3:0], x_r[2*ROOT_STEPS-1 -: 2]};
  assign trial = SREM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      x_r      <= (2*ROOT_STEPS)'(quo_r);
      root_r   <= '0;
      srem_r   <= '0;
      sq_cnt_r <= '0;
    end else if (cmd.sq_step) begin
      x_r      <= {x_r[2*ROOT_STEPS-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + ROOT_CNT_W'(1);
      if (r4 >= trial) begin
        srem_r <= r4 - trial;
        root_r <= {root_r[RMS_W-2:0], 1'b1};
      end else begin
        srem_r <= r4;
        root_r <= {root_r[RMS_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_channel_r  <= ch_r;
      out_chan_rms_r <= chan_rms_r;
      out_overall_r  <= root_r;
    end
  end

  assign status.ch_ok    = ch_ok_r;
  assign status.clr_last = 32'(clr_cnt_r) == DEPTH - 1;
  assign status.div_last = 32'(div_cnt_r) == NW - 1;
  assign status.sq_last  = 32'(sq_cnt_r) == ROOT_STEPS - 1;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_channel_rms = out_chan_rms_r;
  assign out_overall_rms = out_overall_r;

endmodule

### rtl/core/multichannel_window_rms.sv
// top level: per channel sliding window rms with overall rms
//
// in channel: in_valid/in_stall carries one beat of channel and signed sample.
// out channel: out_valid/out_stall carries the echoed channel, the channel rms
// and the overall rms, both unsigned 8.8.
// cfg port: cfg_we/cfg_wdata writes window_len; every write clears all windows.
// one item at a time; a shared one bit a cycle divider runs for the channel
// (only for a channel below CHANNELS) and then for the total, each run followed
// by the 16 step square root. its numerator is TW+16 bits wide, TW being the
// width of the total square sum (25 bits at the default sizes).
// the next beat is taken once the result sits in the output register, even
// while the receiver still stalls it.
// after reset and after each cfg write all CHANNELS*MAX_WINDOW entries of the
// window memory (1024 at the defaults) are cleared with in_stall high.
// a stalled result holds; a finished item waits for the output register.
module multichannel_window_rms import mwr_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int MAX_WINDOW = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [WLEN_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [RMS_W-1:0]    out_channel_rms,
  output logic [RMS_W-1:0]    out_overall_rms
);

  mwr_cmd_t    cmd;
  mwr_status_t status;

  mwr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .cfg_we  (cfg_we),
    .status  (status),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  mwr_dp #(
    .CHANNELS  (CHANNELS),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_channel    (out_channel),
    .out_channel_rms(out_channel_rms),
    .out_overall_rms(out_overall_rms)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous beat in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open after register write");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

### test/tb_multichannel_window_rms.sv
// testbench for the per channel sliding window rms block with overall rms
module tb_multichannel_window_rms import mwr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH    = 8;
  localparam int MAXWIN = 128;
  localparam int MAX_ERR_SHOWN = 10;

  typedef struct {
    logic [CHAN_W-1:0] ch;
    logic [RMS_W-1:0]  chan_rms;
    logic [RMS_W-1:0]  all_rms;
  } rms_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [WLEN_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [CHAN_W-1:0]   in_channel;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_stall;
  logic [CHAN_W-1:0]   out_channel;
  logic [RMS_W-1:0]    out_channel_rms;
  logic [RMS_W-1:0]    out_overall_rms;

  multichannel_window_rms #(.CHANNELS(NCH), .MAX_WINDOW(MAXWIN)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_channel(in_channel),
    .in_sample(in_sample), .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .out_channel_rms(out_channel_rms),
    .out_overall_rms(out_overall_rms)
  );

  // predictor state
  logic [SAMPLE_W-1:0] win_mem [NCH][MAXWIN];
  int unsigned         wr_pos [NCH];
  int unsigned         chan_sq_sum [NCH];
  int unsigned         all_sq_sum;
  logic [WLEN_W-1:0]   win_len_reg;

  rms_result_t expected_rms_q[$];
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4ns * 4_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [RMS_W-1:0] rms_fixed(longint unsigned sum, longint unsigned div);
    longint unsigned r;
    r = int_sqrt((sum << 16) / div);
    if (r > 64'hFFFF) r = 64'hFFFF;
    return r[RMS_W-1:0];
  endfunction

  function automatic int unsigned sample_sq(logic [SAMPLE_W-1:0] s);
    int v;
    v = $signed(s);
    return v * v;
  endfunction

  function automatic void clear_windows();
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < MAXWIN; i++) win_mem[c][i] = '0;
      wr_pos[c] = 0;
      chan_sq_sum[c] = 0;
    end
    all_sq_sum = 0;
  endfunction

  function automatic void predict_rms(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
    int unsigned len;
    int unsigned pos;
    int unsigned old_sq;
    int unsigned new_sq;
    rms_result_t r;
    len = win_len_reg;
    if (len < 1) len = 1;
    if (len > MAXWIN) len = MAXWIN;
    r.ch = ch;
    r.chan_rms = '0;
    if (ch < NCH) begin
      pos = wr_pos[ch];
      if (pos >= len) pos = 0;
      old_sq = sample_sq(win_mem[ch][pos]);
      new_sq = sample_sq(s);
      chan_sq_sum[ch] = chan_sq_sum[ch] - old_sq + new_sq;
      all_sq_sum = all_sq_sum - old_sq + new_sq;
      win_mem[ch][pos] = s;
      pos++;
      if (pos >= len) pos = 0;
      wr_pos[ch] = pos;
      r.chan_rms = rms_fixed(chan_sq_sum[ch], len);
    end
    r.all_rms = rms_fixed(all_sq_sum, len * NCH);
    expected_rms_q.insert(expected_rms_q.size(), r);
  endfunction

  // receiver side stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    rms_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rms_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_ERR_SHOWN)
          $display("unexpected beat: ch %0d rms %0d all %0d", out_channel,
                   out_channel_rms, out_overall_rms);
      end else begin
        e = expected_rms_q.pop_front();
        if (out_channel !== e.ch || out_channel_rms !== e.chan_rms ||
            out_overall_rms !== e.all_rms) begin
          err_cnt++;
          if (err_cnt <= MAX_ERR_SHOWN)
            $display("mismatch: exp ch %0d rms %0d all %0d, got ch %0d rms %0d all %0d",
                     e.ch, e.chan_rms, e.all_rms, out_channel, out_channel_rms,
                     out_overall_rms);
        end
      end
    end
  end

  task automatic send_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rms(ch, s);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rms_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_window_len(logic [WLEN_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len_reg = v;
    clear_windows();
  endtask

  task automatic send_random(int n, int full_pct);
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      s = SAMPLE_W'($urandom);
      if ($urandom_range(99) < full_pct) s = $urandom_range(1) ? 8'h80 : 8'h7F;
      send_sample(CHAN_W'($urandom_range(NCH - 1)), s);
    end
  endtask

  task automatic test_extremes();
    send_sample(3'd0, 8'h80);
    send_sample(3'd7, 8'h7F);
    send_sample(3'd0, 8'h00);
    send_sample(3'd5, 8'hFF);
    send_sample(3'd2, 8'h01);
    send_sample(3'd3, 8'h55);
    send_sample(3'd4, 8'hAA);
    send_sample(3'd6, 8'h80);
    send_sample(3'd1, 8'h80);
  endtask

  task automatic test_short_windows();
    write_window_len(8'd0);
    for (int i = 0; i < 4; i++) send_sample(3'd7, i[0] ? 8'h80 : 8'h7F);
    write_window_len(8'd1);
    send_sample(3'd0, 8'h80);
    send_sample(3'd0, 8'h03);
    write_window_len(8'd2);
    for (int i = 0; i < 5; i++) send_sample(3'd1, 8'h80);
  endtask

  task automatic test_long_windows();
    write_window_len(8'd255);
    send_random(40, 30);
    write_window_len(8'd128);
    for (int i = 0; i < 130; i++) send_sample(3'd6, 8'h80);
    write_window_len(8'd129);
    send_random(20, 10);
  endtask

  task automatic test_backpressure();
    hold_cycles = 1500;
    send_random(12, 20);
    drain();
    send_random(8, 0);
  endtask

  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(3))
        0: write_window_len(WLEN_W'($urandom_range(8, 1)));
        1: write_window_len(WLEN_W'($urandom_range(40, 9)));
        2: write_window_len(WLEN_W'($urandom_range(255, 128)));
        default: write_window_len(WLEN_W'($urandom_range(127, 41)));
      endcase
      send_random(90, 15);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_channel = '0;
    in_sample = '0;
    out_stall = 1'b0;
    err_cnt = 0;
    send_idle_pct = 36;
    recv_idle_pct = 86;
    hold_cycles = 0;
    win_len_reg = WLEN_RESET;
    clear_windows();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_short_windows();
    test_long_windows();
    test_backpressure();
    test_random_phase(36, 86);
    test_random_phase(86, 36);
    test_random_phase(0, 0);

    drain();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### multichannel_window_rms.f
rtl/core/mwr_pkg.sv
rtl/core/mwr_ram.sv
rtl/core/mwr_ctrl.sv
rtl/core/mwr_dp.sv
rtl/core/multichannel_window_rms.sv
test/tb_multichannel_window_rms.sv
